>>> hdl/rwps_pkg.sv
package rwps_pkg;

   // request kinds
   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_SELECT = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // result status codes
   localparam logic [2:0] STATUS_SELECTED = 3'd0;
   localparam logic [2:0] STATUS_NONE     = 3'd1;
   localparam logic [2:0] STATUS_LOADED   = 3'd2;
   localparam logic [2:0] STATUS_FULL     = 3'd3;
   localparam logic [2:0] STATUS_CLEARED  = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SEARCH
   } state_type;

endpackage

>>> hdl/rwps_ram.sv
module rwps_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rwps_cell.sv
module rwps_cell #(
   parameter int IDX_W   = 8,
   parameter int CUM_W   = 40,
   parameter int FRAC_W  = 16,
   parameter int BIT_POS = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tok_in,
   input  logic [IDX_W-1:0]        prefix_in,
   input  logic [IDX_W:0]          count,
   input  logic [CUM_W-1:0]        rd_data,
   input  logic [CUM_W+FRAC_W:0]   product,
   output logic                    tok_out,
   output logic [IDX_W-1:0]        prefix_out,
   output logic [IDX_W-1:0]        probe_out
);

   // probe of this cell sits just below its own index bit
   localparam logic [IDX_W-1:0] OWN_MASK  = IDX_W'((1 << BIT_POS) - 1);
   localparam logic [IDX_W-1:0] NEXT_MASK = OWN_MASK >> 1;
   localparam logic [IDX_W-1:0] OWN_BIT   = IDX_W'(1 << BIT_POS);

   logic                    tok_ff;
   logic [IDX_W-1:0]        prefix_ff;
   logic [IDX_W-1:0]        probe;
   logic                    beyond;
   logic                    reaches;
   logic                    hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in;
   end

   always_comb begin
      probe   = prefix_ff | OWN_MASK;
      // the last member and anything past it count as reached without a read
      beyond  = ({1'b0, probe} + (IDX_W+1)'(1)) >= count;
      reaches = {1'b0, rd_data, FRAC_W'(0)} >= product;
      hit     = beyond || reaches;
      prefix_out = hit ? prefix_ff : (prefix_ff | OWN_BIT);
      probe_out  = prefix_out | NEXT_MASK;
   end

   assign tok_out = tok_ff;

endmodule

>>> hdl/roulette_wheel_parent_select_unit.sv
// Roulette wheel parent selection. A load request appends a fitness value and stores the
// running cumulative sum in a POP_MAX-entry memory; a clear request empties the population
// at once (no clearing pass); a select request returns the first index whose cumulative sum,
// scaled by 2^PICK_FRAC_BITS, reaches pick times total, or the last index if none does.
// Loads, clears and trivial selects write their result into the output register once it is
// free, then the unit returns to idle to take the next request. A real select multiplies pick
// by total once, then runs a bitwise binary search down a chain of log2(POP_MAX) cells, one
// memory read per index bit; its result is registered when the token leaves the last cell,
// and the unit then returns to idle for the next request.
// One request is in work at a time; a finished result waits in the output register while
// the next request is taken.
module roulette_wheel_parent_select_unit #(
   parameter int POP_MAX        = 256,
   parameter int FITNESS_BITS   = 32,
   parameter int PICK_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [FITNESS_BITS-1:0]   req_fitness_value,
   input  logic [PICK_FRAC_BITS:0]   req_pick_fraction,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_parent_index,
   output logic [2:0]                rsp_status
);

   import rwps_pkg::*;

   localparam int IDX_W  = $clog2(POP_MAX);
   localparam int CNT_W  = IDX_W + 1;
   localparam int CUM_W  = FITNESS_BITS + IDX_W;
   localparam int PICK_W = PICK_FRAC_BITS + 1;
   localparam int PROD_W = CUM_W + PICK_W;

   localparam logic [CNT_W-1:0] POP_FULL    = CNT_W'(POP_MAX);
   localparam logic [IDX_W-1:0] FIRST_PROBE = IDX_W'((1 << (IDX_W - 1)) - 1);

   state_type state_ff, state_in;

   logic [1:0]              kind_ff;
   logic [FITNESS_BITS-1:0] fit_ff;
   logic [PICK_W-1:0]       pick_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CUM_W-1:0]  total_ff, total_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CUM_W-1:0]  sum;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_index_ff, rsp_index_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic       slot_free;

   logic             wr_en;
   logic [IDX_W-1:0] rd_addr;
   logic [CUM_W-1:0] rd_data;
   logic             start;

   logic             tok_chain    [IDX_W+1];
   logic [IDX_W-1:0] prefix_chain [IDX_W+1];
   logic [IDX_W-1:0] probe_chain  [IDX_W];
   logic [IDX_W+7:0] idx_ext;

   rwps_ram #(
      .WIDTH (CUM_W),
      .DEPTH (POP_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (sum),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign tok_chain[0]    = start;
   assign prefix_chain[0] = '0;

   // cell k settles index bit IDX_W-1-k
   for (genvar k = 0; k < IDX_W; k++) begin : g_cell
      rwps_cell #(
         .IDX_W   (IDX_W),
         .CUM_W   (CUM_W),
         .FRAC_W  (PICK_FRAC_BITS),
         .BIT_POS (IDX_W - 1 - k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_in     (tok_chain[k]),
         .prefix_in  (prefix_chain[k]),
         .count      (count_ff),
         .rd_data    (rd_data),
         .product    (prod_ff),
         .tok_out    (tok_chain[k+1]),
         .prefix_out (prefix_chain[k+1]),
         .probe_out  (probe_chain[k])
      );
   end

   // only one cell holds the token, so its probe drives the read port
   always_comb begin
      rd_addr = start ? FIRST_PROBE : '0;
      for (int k = 0; k < IDX_W; k++) begin
         if (tok_chain[k+1]) begin
            rd_addr = rd_addr | probe_chain[k];
         end
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign sum       = total_ff + CUM_W'(fit_ff);
   assign idx_ext   = {8'b0, prefix_chain[IDX_W]};

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      count_in      = count_ff;
      total_in      = total_ff;
      prod_in       = prod_ff;
      wr_en         = 1'b0;
      start         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // state only changes once the result register is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               state_in     = S_IDLE;
               case (kind_ff)
                  KIND_LOAD: begin
                     if (count_ff >= POP_FULL) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        total_in      = sum;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = STATUS_LOADED;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in      = '0;
                     total_in      = '0;
                     rsp_status_in = STATUS_CLEARED;
                  end
                  KIND_SELECT: begin
                     if (pick_ff == '0 || count_ff == '0) begin
                        rsp_status_in = STATUS_NONE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        start        = 1'b1;
                        prod_in      = PROD_W'(pick_ff) * PROD_W'(total_ff);
                        state_in     = S_SEARCH;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_NONE;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (tok_chain[IDX_W]) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = idx_ext[7:0];
               rsp_status_in = STATUS_SELECTED;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff <= req_kind;
         fit_ff  <= req_fitness_value;
         pick_ff <= req_pick_fraction;
      end
      prod_ff       <= prod_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parent_index = rsp_index_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
